// ----- hdl/tccs_pkg.sv -----
// ----------------------------------------------------------------------------
// tccs_pkg: shared definitions for the text console engine
// Screen geometry, request codes, memory request bundle and cursor helpers.
// ----------------------------------------------------------------------------
package tccs_pkg;

  // Screen geometry
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int TAB_STEP   = 4;

  // Widths derived from the geometry
  localparam int CELL_W = $clog2(CELL_COUNT);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int COLT_W = $clog2(COLUMNS + TAB_STEP);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int ROWT_W = $clog2(ROWS + 1);

  // Field widths
  localparam int REQ_W   = 2;
  localparam int CHAR_W  = 8;
  localparam int IDX_W   = 11;
  localparam int POS_W   = 11;
  localparam int DATA_W  = 16;
  localparam int COLOR_W = 8;
  localparam int POSF_W  = (CELL_W > POS_W) ? CELL_W : POS_W;

  // Configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_TEXT_COLOR = 1'b0;
  localparam logic [COLOR_W-1:0] TEXT_COLOR_RESET = 8'h0F;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
  localparam logic [CHAR_W-1:0] CH_BLANK   = 8'h20;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUT   = 2'd0,
    REQ_CLEAR = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  // One cycle's worth of cell memory traffic
  typedef struct packed {
    logic              we;
    logic [CELL_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [CELL_W-1:0] raddr;
  } mem_req_t;

  // Linear cell address of a cursor position
  function automatic logic [CELL_W-1:0] lin_pos(input logic [ROW_W-1:0] row,
                                                input logic [COL_W-1:0] col);
    lin_pos = CELL_W'(row) * CELL_W'(COLUMNS) + CELL_W'(col);
  endfunction

  // Cursor position as reported on the result port
  function automatic logic [POS_W-1:0] cursor_out(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    logic [POSF_W-1:0] full;
    full = POSF_W'(lin_pos(row, col));
    cursor_out = full[POS_W-1:0];
  endfunction

endpackage

// ----- hdl/tccs_ram.sv -----
// ----------------------------------------------------------------------------
// tccs_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module tccs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/tccs_cfg.sv -----
// ----------------------------------------------------------------------------
// tccs_cfg: configuration register block
// APB-style access to the text color register.
// ----------------------------------------------------------------------------
module tccs_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tccs_pkg::PADDR_W-1:0]  paddr,
  input  logic [tccs_pkg::PDATA_W-1:0]  pwdata,
  output logic [tccs_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output logic [tccs_pkg::COLOR_W-1:0]  text_color
);
  import tccs_pkg::*;

  logic [COLOR_W-1:0] text_color_r;
  logic               wr_hit;

  // pready is tied high
  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_TEXT_COLOR);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_color_r <= TEXT_COLOR_RESET;
    end else if (wr_hit) begin
      text_color_r <= pwdata[COLOR_W-1:0];
    end
  end

  // Read-back
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_TEXT_COLOR) begin
      prdata = PDATA_W'(text_color_r);
    end
  end

  assign text_color = text_color_r;

endmodule

// ----- hdl/tccs_engine.sv -----
// ----------------------------------------------------------------------------
// tccs_engine: request sequencer for the text console
// Tracks the cursor, issues cell writes, serves cell reads, and sweeps the cell memory for
// scroll and clear.
// ----------------------------------------------------------------------------
module tccs_engine (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [tccs_pkg::REQ_W-1:0]    in_req_type,
  input  logic [tccs_pkg::CHAR_W-1:0]   in_char_code,
  input  logic [tccs_pkg::IDX_W-1:0]    in_cell_index,
  input  logic [tccs_pkg::COLOR_W-1:0]  text_color,
  output logic                          out_valid,
  output logic [tccs_pkg::POS_W-1:0]    out_cursor_loc,
  output logic [tccs_pkg::DATA_W-1:0]   out_cell_data,
  output tccs_pkg::mem_req_t            mem_req,
  input  logic [tccs_pkg::DATA_W-1:0]   mem_rdata
);
  import tccs_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_READ  = 4'b0010,
    ST_SWEEP = 4'b0100,
    ST_DRAIN = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  logic [ROW_W-1:0]    row_r, row_nxt;
  logic [COL_W-1:0]    col_r, col_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                pend_vld_r, pend_vld_nxt;
  logic [CELL_W-1:0]   pend_addr_r, pend_addr_nxt;
  logic                pend_copy_r, pend_copy_nxt;
  logic [CELL_W-1:0]   cnt_r, cnt_nxt;
  logic                copy_mode_r, copy_mode_nxt;
  logic                rd_oob_r, rd_oob_nxt;
  logic [DATA_W-1:0]   cell_data_r, cell_data_nxt;

  logic [COLT_W-1:0]   put_col_ext;
  logic [ROWT_W-1:0]   put_row_ext;
  logic                put_scroll;
  logic                put_write;
  logic                idx_ok;
  logic                sweep_copy;
  logic                accept;
  logic [DATA_W-1:0]   blank_word;

  assign accept     = start && (state_r == ST_IDLE);
  assign blank_word = {text_color, CH_BLANK};
  assign idx_ok     = 32'(in_cell_index) < CELL_COUNT;
  assign put_write  = (in_char_code != CH_NEWLINE) && (in_char_code != CH_TAB);
  assign sweep_copy = copy_mode_r && (cnt_r < CELL_W'(CELL_COUNT - COLUMNS));

  // Cursor advance for a put request
  always_comb begin
    put_col_ext = COLT_W'(col_r);
    put_row_ext = ROWT_W'(row_r);
    if (in_char_code == CH_NEWLINE) begin
      put_row_ext = put_row_ext + 1'b1;
      put_col_ext = '0;
    end else if (in_char_code == CH_TAB) begin
      put_col_ext = put_col_ext + COLT_W'(TAB_STEP);
    end else begin
      put_col_ext = put_col_ext + 1'b1;
    end
    if (put_col_ext >= COLT_W'(COLUMNS)) begin
      put_row_ext = put_row_ext + 1'b1;
      put_col_ext = '0;
    end
    put_scroll = put_row_ext > ROWT_W'(ROWS - 1);
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    out_valid_nxt = 1'b0;
    pend_vld_nxt  = 1'b0;
    pend_addr_nxt = pend_addr_r;
    pend_copy_nxt = pend_copy_r;
    cnt_nxt       = cnt_r;
    copy_mode_nxt = copy_mode_r;
    rd_oob_nxt    = rd_oob_r;
    cell_data_nxt = cell_data_r;
    mem_req       = '0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cell_data_nxt = '0;
          case (in_req_type)
            REQ_PUT: begin
              mem_req.we    = put_write;
              mem_req.waddr = lin_pos(row_r, col_r);
              mem_req.wdata = {text_color, in_char_code};
              col_nxt       = put_col_ext[COL_W-1:0];
              if (put_scroll) begin
                row_nxt       = ROW_W'(ROWS - 1);
                state_nxt     = ST_SWEEP;
                cnt_nxt       = '0;
                copy_mode_nxt = 1'b1;
              end else begin
                row_nxt       = put_row_ext[ROW_W-1:0];
                out_valid_nxt = 1'b1;
              end
            end
            REQ_CLEAR: begin
              row_nxt       = '0;
              col_nxt       = '0;
              state_nxt     = ST_SWEEP;
              cnt_nxt       = '0;
              copy_mode_nxt = 1'b0;
            end
            REQ_READ: begin
              mem_req.re    = 1'b1;
              mem_req.raddr = idx_ok ? CELL_W'(in_cell_index) : '0;
              rd_oob_nxt    = !idx_ok;
              state_nxt     = ST_READ;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        cell_data_nxt = rd_oob_r ? '0 : mem_rdata;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      ST_SWEEP: begin
        // Copy mode: read the cell one row down, write it back in the next cycle; else write a blank
        mem_req.re    = sweep_copy;
        mem_req.raddr = sweep_copy ? cnt_r + CELL_W'(COLUMNS) : '0;
        pend_vld_nxt  = 1'b1;
        pend_addr_nxt = cnt_r;
        pend_copy_nxt = sweep_copy;
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == CELL_W'(CELL_COUNT - 1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Write stage of the sweep
    if (pend_vld_r) begin
      mem_req.we    = 1'b1;
      mem_req.waddr = pend_addr_r;
      mem_req.wdata = pend_copy_r ? mem_rdata : blank_word;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      row_r       <= '0;
      col_r       <= '0;
      out_valid_r <= 1'b0;
      pend_vld_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      out_valid_r <= out_valid_nxt;
      pend_vld_r  <= pend_vld_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    pend_addr_r <= pend_addr_nxt;
    pend_copy_r <= pend_copy_nxt;
    cnt_r       <= cnt_nxt;
    copy_mode_r <= copy_mode_nxt;
    rd_oob_r    <= rd_oob_nxt;
    cell_data_r <= cell_data_nxt;
  end

  assign busy           = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_cursor_loc = cursor_out(row_r, col_r);
  assign out_cell_data  = cell_data_r;

  // Checks
  a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_req_type == REQ_READ) |-> ##2 out_valid_r)
    else $error("read request did not complete in two cycles");

  a_sweep_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_req.we && mem_req.re) |-> (mem_req.waddr != mem_req.raddr))
    else $error("cell write and read hit the same address");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(row_r) < ROWS) && (32'(col_r) < COLUMNS))
    else $error("cursor outside the screen");

  a_drain_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("sweep finished without a result");

endmodule

// ----- hdl/text_console_cursor_scroll.sv -----
// ----------------------------------------------------------------------------
// text_console_cursor_scroll: text-mode console engine
// Cursor tracking, character writes, scroll, clear and cell read-back over
// an 80x25 store of 16-bit cells.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its transaction
// completes with one out_valid pulse, and the receiver must take it in that
// cycle. A put (plain character, newline or tab) with no scroll returns its
// result in the next cycle and keeps busy low, so puts can be issued every
// cycle. A read passes through the read state, which captures the registered
// cell data and returns it. A clear, or a put that runs past the bottom row,
// sweeps every cell of the single-port-write cell memory once, one cell per
// cycle, then issues its result from the drain state; busy is high throughout.
// The cell memory is not cleared at reset; issue a clear before reading.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [tccs_pkg::REQ_W-1:0]    in_req_type,
  input  logic [tccs_pkg::CHAR_W-1:0]   in_char_code,
  input  logic [tccs_pkg::IDX_W-1:0]    in_cell_index,
  output logic                          out_valid,
  output logic [tccs_pkg::POS_W-1:0]    out_cursor_loc,
  output logic [tccs_pkg::DATA_W-1:0]   out_cell_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tccs_pkg::PADDR_W-1:0]  paddr,
  input  logic [tccs_pkg::PDATA_W-1:0]  pwdata,
  output logic [tccs_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import tccs_pkg::*;

  logic [COLOR_W-1:0] text_color;
  mem_req_t           mem_req;
  logic [DATA_W-1:0]  mem_rdata;

  // Configuration registers
  tccs_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .text_color (text_color)
  );

  // Request sequencer
  tccs_engine u_engine (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_req_type    (in_req_type),
    .in_char_code   (in_char_code),
    .in_cell_index  (in_cell_index),
    .text_color     (text_color),
    .out_valid      (out_valid),
    .out_cursor_loc (out_cursor_loc),
    .out_cell_data  (out_cell_data),
    .mem_req        (mem_req),
    .mem_rdata      (mem_rdata)
  );

  // Cell store
  tccs_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CELL_COUNT)
  ) u_cells (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

endmodule
